// ===== hw/rtl/mase_pkg.sv =====
// ============================================================================
// mase_pkg
// Shared types and constants of the integer matrix add/subtract/multiply engine.
// ============================================================================
package mase_pkg;

    // Widths fixed by the interface.
    localparam int WORD_W      = 32;
    localparam int OP_W        = 2;
    localparam int POS_W       = 3;
    localparam int CFG_DIM_W   = 4;
    localparam int CFG_MODE_W  = 2;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 4;
    localparam int MAX_RESULTS = 64;
    localparam int CNT_W       = $clog2(MAX_RESULTS);

    // Input operation codes.
    localparam logic [OP_W-1:0] OP_LOAD_A = 2'd0;
    localparam logic [OP_W-1:0] OP_LOAD_B = 2'd1;
    localparam logic [OP_W-1:0] OP_START  = 2'd2;

    // Mode register codes.
    localparam logic [CFG_MODE_W-1:0] MODE_ADD    = 2'd0;
    localparam logic [CFG_MODE_W-1:0] MODE_SUB    = 2'd1;
    localparam logic [CFG_MODE_W-1:0] MODE_MUL    = 2'd2;
    localparam logic [CFG_MODE_W-1:0] MODE_UNUSED = 2'd3;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_ROWS_A = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COLS_A = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ROWS_B = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_COLS_B = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MODE   = 3'd4;

    typedef enum logic [1:0] {
        KIND_ADD,
        KIND_SUB,
        KIND_MUL
    } t_kind;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_WAIT
    } t_state;

    // Configuration register file.
    typedef struct packed {
        logic [CFG_DIM_W-1:0]  rows_a;
        logic [CFG_DIM_W-1:0]  cols_a;
        logic [CFG_DIM_W-1:0]  rows_b;
        logic [CFG_DIM_W-1:0]  cols_b;
        logic [CFG_MODE_W-1:0] mode;
    } t_cfg;

    // Control tag that travels with each pair of memory reads.
    typedef struct packed {
        logic             valid;
        t_kind            kind;
        logic             first;    // first product of a dot product
        logic             lastk;    // last term: the element is complete
        logic             lastres;  // final word of the computation
        logic             err;      // dimension mismatch word
        logic [POS_W-1:0] row;
        logic [POS_W-1:0] col;
    } t_tag;

    // One result word.
    typedef struct packed {
        logic              valid;
        logic [POS_W-1:0]  row;
        logic [POS_W-1:0]  col;
        logic [WORD_W-1:0] value;
        logic              last;
        logic              status;
    } t_result;

endpackage

// ===== hw/rtl/mase_store.sv =====
// ============================================================================
// mase_store
// Element store: one write port and one read port, read data registered.
// ============================================================================
module mase_store #(
    parameter int DEPTH  = 64,
    parameter int ADDR_W = 6
) (
    input  logic                        i_clk,
    input  logic                        i_we,
    input  logic [ADDR_W-1:0]           i_waddr,
    input  logic [mase_pkg::WORD_W-1:0] i_wdata,
    input  logic [ADDR_W-1:0]           i_raddr,
    output logic [mase_pkg::WORD_W-1:0] o_rdata
);

    logic [mase_pkg::WORD_W-1:0] r_mem [DEPTH];
    logic [mase_pkg::WORD_W-1:0] r_rdata;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hw/rtl/mase_mac.sv =====
// ============================================================================
// mase_mac
// Arithmetic pipeline: operand stage, add/subtract/multiply stage, and the
// accumulate stage that drives the result word.
// ============================================================================
module mase_mac (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  mase_pkg::t_tag              i_tag,
    input  logic [mase_pkg::WORD_W-1:0] i_a_data,
    input  logic [mase_pkg::WORD_W-1:0] i_b_data,
    output mase_pkg::t_result           o_result
);

    mase_pkg::t_tag              r_tag1;
    mase_pkg::t_tag              r_tag2;
    logic [mase_pkg::WORD_W-1:0] r_prod;
    logic [mase_pkg::WORD_W-1:0] n_prod;
    logic [mase_pkg::WORD_W-1:0] r_acc;
    logic [mase_pkg::WORD_W-1:0] n_acc;
    mase_pkg::t_result           r_out;

    // Tags follow the memory read latency and the arithmetic stage.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag1 <= '0;
            r_tag2 <= '0;
        end else begin
            r_tag1 <= i_tag;
            r_tag2 <= r_tag1;
        end
    end

    // Element operation on the words just read; products wrap to 32 bits.
    always_comb begin
        case (r_tag1.kind)
            mase_pkg::KIND_ADD: n_prod = i_a_data + i_b_data;
            mase_pkg::KIND_SUB: n_prod = i_a_data - i_b_data;
            mase_pkg::KIND_MUL: n_prod = i_a_data * i_b_data;
            default:            n_prod = i_a_data + i_b_data;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_prod <= n_prod;
    end

    // Accumulator restarts on the first term of each element.
    assign n_acc = r_tag2.first ? r_prod : (r_acc + r_prod);

    always_ff @(posedge i_clk) begin
        if (r_tag2.valid) begin
            r_acc <= n_acc;
        end
    end

    // Result word register: the strobe lasts exactly one cycle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out.valid <= 1'b0;
        end else begin
            r_out.valid <= r_tag2.valid && r_tag2.lastk;
        end
        if (r_tag2.valid && r_tag2.lastk) begin
            r_out.row    <= r_tag2.row;
            r_out.col    <= r_tag2.col;
            r_out.value  <= r_tag2.err ? '0 : n_acc;
            r_out.last   <= r_tag2.lastres;
            r_out.status <= r_tag2.err;
        end
    end

    assign o_result = r_out;

endmodule

// ===== hw/rtl/mase_ctrl.sv =====
// ============================================================================
// mase_ctrl
// Sequencer: checks the sizes on start and walks rows, columns and dot-product
// terms, issuing one pair of store reads per cycle with its control tag.
// ============================================================================
module mase_ctrl #(
    parameter int MAX_DIM = 8,
    parameter int IDX_W   = 3,
    parameter int ADDR_W  = 6
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_go,
    input  mase_pkg::t_cfg      i_cfg,
    input  logic                i_done,
    output logic                o_busy,
    output mase_pkg::t_tag      o_tag,
    output logic [ADDR_W-1:0]   o_a_addr,
    output logic [ADDR_W-1:0]   o_b_addr
);

    localparam int DIM_W = $clog2(MAX_DIM + 1);
    localparam int TOT_W = 2 * DIM_W;

    mase_pkg::t_state         r_state;
    mase_pkg::t_state         n_state;
    logic [IDX_W-1:0]         r_i, n_i;
    logic [IDX_W-1:0]         r_j, n_j;
    logic [IDX_W-1:0]         r_k, n_k;
    logic [IDX_W-1:0]         r_nc_m1, n_nc_m1;
    logic [IDX_W-1:0]         r_k_last, n_k_last;
    mase_pkg::t_kind          r_kind, n_kind;
    logic                     r_err, n_err;
    logic [mase_pkg::CNT_W-1:0] r_cnt, n_cnt;
    logic [mase_pkg::CNT_W-1:0] r_total_m1, n_total_m1;

    logic [DIM_W-1:0] ra, ca, rb, cb, nr, nc;
    logic [TOT_W-1:0] total;
    logic             is_mul;
    logic             lastk;
    logic             lastres;
    logic [IDX_W-1:0] a_col, b_row;

    // Size register clamped to 1..MAX_DIM.
    function automatic logic [DIM_W-1:0] eff_dim(input logic [mase_pkg::CFG_DIM_W-1:0] v);
        logic [mase_pkg::CFG_DIM_W:0] wide;
        wide = {1'b0, v};
        if (v == '0) begin
            eff_dim = DIM_W'(1);
        end else if (int'(wide) > MAX_DIM) begin
            eff_dim = DIM_W'(MAX_DIM);
        end else begin
            eff_dim = DIM_W'(wide);
        end
    endfunction

    // Effective sizes and the setup values captured on start.
    always_comb begin
        ra     = eff_dim(i_cfg.rows_a);
        ca     = eff_dim(i_cfg.cols_a);
        rb     = eff_dim(i_cfg.rows_b);
        cb     = eff_dim(i_cfg.cols_b);
        is_mul = (i_cfg.mode == mase_pkg::MODE_MUL);
        nr     = ra;
        nc     = is_mul ? cb : ca;
        total  = TOT_W'(nr) * TOT_W'(nc);
    end

    // Position of the current term within the computation.
    assign lastk   = (r_k == r_k_last);
    assign lastres = lastk && (r_cnt == r_total_m1);

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            mase_pkg::ST_IDLE: begin
                if (i_go) begin
                    n_state = mase_pkg::ST_RUN;
                end
            end
            mase_pkg::ST_RUN: begin
                if (r_err || lastres) begin
                    n_state = mase_pkg::ST_WAIT;
                end
            end
            mase_pkg::ST_WAIT: begin
                if (i_done) begin
                    n_state = mase_pkg::ST_IDLE;
                end
            end
            default: n_state = mase_pkg::ST_IDLE;
        endcase
    end

    // Setup capture and counter advance.
    always_comb begin
        n_i        = r_i;
        n_j        = r_j;
        n_k        = r_k;
        n_nc_m1    = r_nc_m1;
        n_k_last   = r_k_last;
        n_kind     = r_kind;
        n_err      = r_err;
        n_cnt      = r_cnt;
        n_total_m1 = r_total_m1;
        if (r_state == mase_pkg::ST_IDLE && i_go) begin
            n_i      = '0;
            n_j      = '0;
            n_k      = '0;
            n_cnt    = '0;
            n_nc_m1  = IDX_W'(nc - DIM_W'(1));
            n_k_last = is_mul ? IDX_W'(ca - DIM_W'(1)) : '0;
            n_err    = is_mul ? (ca != rb) : ((ra != rb) || (ca != cb));
            case (i_cfg.mode)
                mase_pkg::MODE_SUB: n_kind = mase_pkg::KIND_SUB;
                mase_pkg::MODE_MUL: n_kind = mase_pkg::KIND_MUL;
                default:            n_kind = mase_pkg::KIND_ADD;
            endcase
            if (int'(total) > mase_pkg::MAX_RESULTS) begin
                n_total_m1 = mase_pkg::CNT_W'(mase_pkg::MAX_RESULTS - 1);
            end else begin
                n_total_m1 = mase_pkg::CNT_W'(total - TOT_W'(1));
            end
        end else if (r_state == mase_pkg::ST_RUN && !r_err) begin
            if (lastk) begin
                n_k   = '0;
                n_cnt = r_cnt + mase_pkg::CNT_W'(1);
                if (r_j == r_nc_m1) begin
                    n_j = '0;
                    n_i = r_i + IDX_W'(1);
                end else begin
                    n_j = r_j + IDX_W'(1);
                end
            end else begin
                n_k = r_k + IDX_W'(1);
            end
        end
    end

    // Outputs: read addresses and the tag that goes with them.
    always_comb begin
        a_col         = (r_kind == mase_pkg::KIND_MUL) ? r_k : r_j;
        b_row         = (r_kind == mase_pkg::KIND_MUL) ? r_k : r_i;
        o_a_addr      = ADDR_W'(r_i) * ADDR_W'(MAX_DIM) + ADDR_W'(a_col);
        o_b_addr      = ADDR_W'(b_row) * ADDR_W'(MAX_DIM) + ADDR_W'(r_j);
        o_tag.valid   = (r_state == mase_pkg::ST_RUN);
        o_tag.kind    = r_kind;
        o_tag.first   = r_err || (r_k == '0);
        o_tag.lastk   = r_err || lastk;
        o_tag.lastres = r_err || lastres;
        o_tag.err     = r_err;
        o_tag.row     = r_err ? '0 : mase_pkg::POS_W'(r_i);
        o_tag.col     = r_err ? '0 : mase_pkg::POS_W'(r_j);
        o_busy        = (r_state != mase_pkg::ST_IDLE);
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mase_pkg::ST_IDLE;
            r_i     <= '0;
            r_j     <= '0;
            r_k     <= '0;
            r_cnt   <= '0;
            r_err   <= 1'b0;
            r_kind  <= mase_pkg::KIND_ADD;
        end else begin
            r_state <= n_state;
            r_i     <= n_i;
            r_j     <= n_j;
            r_k     <= n_k;
            r_cnt   <= n_cnt;
            r_err   <= n_err;
            r_kind  <= n_kind;
        end
    end

    // Limits captured on start.
    always_ff @(posedge i_clk) begin
        r_nc_m1    <= n_nc_m1;
        r_k_last   <= n_k_last;
        r_total_m1 <= n_total_m1;
    end

endmodule

// ===== hw/rtl/matrix_add_sub_mul_engine_top.sv =====
// ============================================================================
// matrix_add_sub_mul_engine_top
// Integer matrix engine: loads elements of A and B into two stores and runs
// element-wise add, subtract or matrix product on start.
// ============================================================================
//
//  Channel   | Handshake                  | Word
//  ----------+----------------------------+---------------------------------
//  command   | start, busy                | operation, row, col, value
//  result    | o_valid (one-cycle strobe) | out_row, out_col, result_value,
//            |                            | last, status
//  config    | i_cfg_we                   | i_cfg_idx, i_cfg_data
//
//  A load leaves busy low. A start holds busy high until the final result word is
//  out, with one store read pair per cycle: rows x columns for add and subtract,
//  rows x columns x inner size for multiply (one shared multiplier, one product
//  per cycle). The first result word follows start through the sequencer state,
//  store read, operation and result registers. Reset returns the control state
//  to idle and the configuration to sizes of 1 and add mode; store contents are
//  undefined until loaded. The receiver cannot stall the result words.
//
module matrix_add_sub_mul_engine_top #(
    parameter int MAX_DIM = 8
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  logic [mase_pkg::OP_W-1:0]            i_operation,
    input  logic [mase_pkg::POS_W-1:0]           i_row,
    input  logic [mase_pkg::POS_W-1:0]           i_col,
    input  logic signed [mase_pkg::WORD_W-1:0]   i_value,
    output logic                                 o_valid,
    output logic [mase_pkg::POS_W-1:0]           o_out_row,
    output logic [mase_pkg::POS_W-1:0]           o_out_col,
    output logic signed [mase_pkg::WORD_W-1:0]   o_result_value,
    output logic                                 o_last,
    output logic                                 o_status,
    input  logic                                 i_cfg_we,
    input  logic [mase_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [mase_pkg::CFG_DATA_W-1:0]      i_cfg_data
);

    localparam int IDX_W  = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
    localparam int DEPTH  = MAX_DIM * MAX_DIM;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    mase_pkg::t_cfg    r_cfg;
    mase_pkg::t_tag    tag;
    mase_pkg::t_result result;
    logic              accept;
    logic              in_range;
    logic              we_a, we_b;
    logic              go;
    logic [ADDR_W-1:0] waddr;
    logic [ADDR_W-1:0] a_addr, b_addr;
    logic [mase_pkg::WORD_W-1:0] a_data, b_data;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.rows_a <= mase_pkg::CFG_DIM_W'(1);
            r_cfg.cols_a <= mase_pkg::CFG_DIM_W'(1);
            r_cfg.rows_b <= mase_pkg::CFG_DIM_W'(1);
            r_cfg.cols_b <= mase_pkg::CFG_DIM_W'(1);
            r_cfg.mode   <= mase_pkg::MODE_ADD;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                mase_pkg::CFG_ROWS_A: r_cfg.rows_a <= i_cfg_data;
                mase_pkg::CFG_COLS_A: r_cfg.cols_a <= i_cfg_data;
                mase_pkg::CFG_ROWS_B: r_cfg.rows_b <= i_cfg_data;
                mase_pkg::CFG_COLS_B: r_cfg.cols_b <= i_cfg_data;
                mase_pkg::CFG_MODE:   r_cfg.mode   <= i_cfg_data[mase_pkg::CFG_MODE_W-1:0];
                default: ;
            endcase
        end
    end

    // Command decode. Loads reach the stores only while idle, so a store
    // write never overlaps a read of a running computation.
    assign accept   = start && !busy;
    assign in_range = (int'(i_row) < MAX_DIM) && (int'(i_col) < MAX_DIM);
    assign waddr    = ADDR_W'(i_row) * ADDR_W'(MAX_DIM) + ADDR_W'(i_col);
    assign we_a     = accept && (i_operation == mase_pkg::OP_LOAD_A) && in_range;
    assign we_b     = accept && (i_operation == mase_pkg::OP_LOAD_B) && in_range;
    assign go       = accept && (i_operation == mase_pkg::OP_START)
                      && (r_cfg.mode != mase_pkg::MODE_UNUSED);

    // Element stores.
    mase_store #(
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W)
    ) u_store_a (
        .i_clk   (i_clk),
        .i_we    (we_a),
        .i_waddr (waddr),
        .i_wdata (i_value),
        .i_raddr (a_addr),
        .o_rdata (a_data)
    );

    mase_store #(
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W)
    ) u_store_b (
        .i_clk   (i_clk),
        .i_we    (we_b),
        .i_waddr (waddr),
        .i_wdata (i_value),
        .i_raddr (b_addr),
        .o_rdata (b_data)
    );

    // Sequencer.
    mase_ctrl #(
        .MAX_DIM (MAX_DIM),
        .IDX_W   (IDX_W),
        .ADDR_W  (ADDR_W)
    ) u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_go     (go),
        .i_cfg    (r_cfg),
        .i_done   (result.valid && result.last),
        .o_busy   (busy),
        .o_tag    (tag),
        .o_a_addr (a_addr),
        .o_b_addr (b_addr)
    );

    // Arithmetic pipeline.
    mase_mac u_mac (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_tag    (tag),
        .i_a_data (a_data),
        .i_b_data (b_data),
        .o_result (result)
    );

    // Result ports.
    assign o_valid        = result.valid;
    assign o_out_row      = result.row;
    assign o_out_col      = result.col;
    assign o_result_value = result.value;
    assign o_last         = result.last;
    assign o_status       = result.status;

    // Result words only come out while a computation is running.
    a_valid_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> busy)
        else $error("result word outside a computation");

    // The final word of a computation releases the engine.
    a_last_release: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_last) |=> !busy)
        else $error("engine still busy after final word");

    // A mismatch word is a single, final, zero word.
    a_err_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status) |-> (o_last && o_result_value == 0))
        else $error("malformed mismatch word");

    // Store writes never happen during a computation.
    a_store_interlock: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (we_a || we_b) |-> !busy)
        else $error("store written while busy");

endmodule

// ===== tb/matrix_add_sub_mul_engine_top_tb.sv =====
// ============================================================================
// matrix_add_sub_mul_engine_top_tb
// Self-checking bench for the matrix engine: a queue-fed command driver, an
// in-bench matrix calculator that predicts every result word, and a monitor
// that checks each result word against the oldest prediction. Directed
// corner cases come first, then randomized phases with varied sizes, modes
// and sender idling.
// ============================================================================
module matrix_add_sub_mul_engine_top_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_DIM = 8;
    localparam int DEPTH   = MAX_DIM * MAX_DIM;

    // Operation code 3 is not assigned in the package; the block ignores it.
    localparam logic [mase_pkg::OP_W-1:0] OP_UNUSED = 2'd3;

    typedef struct {
        logic [mase_pkg::OP_W-1:0]   op;
        logic [mase_pkg::POS_W-1:0]  row;
        logic [mase_pkg::POS_W-1:0]  col;
        logic [mase_pkg::WORD_W-1:0] value;
    } t_cmd_word;

    typedef struct {
        logic [mase_pkg::POS_W-1:0]  row;
        logic [mase_pkg::POS_W-1:0]  col;
        logic [mase_pkg::WORD_W-1:0] value;
        logic                        last;
        logic                        status;
    } t_elem_word;

    // Clock, reset and DUT ports.
    logic                                  i_clk          = 1'b0;
    logic                                  i_rst_n        = 1'b0;
    logic                                  start          = 1'b0;
    logic                                  busy;
    logic [mase_pkg::OP_W-1:0]             i_operation    = '0;
    logic [mase_pkg::POS_W-1:0]            i_row          = '0;
    logic [mase_pkg::POS_W-1:0]            i_col          = '0;
    logic signed [mase_pkg::WORD_W-1:0]    i_value        = '0;
    logic                                  o_valid;
    logic [mase_pkg::POS_W-1:0]            o_out_row;
    logic [mase_pkg::POS_W-1:0]            o_out_col;
    logic signed [mase_pkg::WORD_W-1:0]    o_result_value;
    logic                                  o_last;
    logic                                  o_status;
    logic                                  i_cfg_we       = 1'b0;
    logic [mase_pkg::CFG_IDX_W-1:0]        i_cfg_idx      = '0;
    logic [mase_pkg::CFG_DATA_W-1:0]       i_cfg_data     = '0;

    // Bench state.
    t_cmd_word         cmd_q[$];
    t_elem_word        elem_q[$];
    int                error_count   = 0;
    int                send_idle_pct = 0;

    // Calculator copy of the stores and the registers.
    logic [mase_pkg::WORD_W-1:0] calc_a[DEPTH];
    logic [mase_pkg::WORD_W-1:0] calc_b[DEPTH];
    mase_pkg::t_cfg              calc_cfg;

    // Generator view: effective sizes and which elements hold data.
    int                gen_ra = 1, gen_ca = 1, gen_rb = 1, gen_cb = 1;
    logic [mase_pkg::CFG_MODE_W-1:0] gen_mode = mase_pkg::MODE_ADD;
    bit [DEPTH-1:0]    a_loaded = '0;
    bit [DEPTH-1:0]    b_loaded = '0;

    matrix_add_sub_mul_engine_top #(
        .MAX_DIM(MAX_DIM)
    ) u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_operation   (i_operation),
        .i_row         (i_row),
        .i_col         (i_col),
        .i_value       (i_value),
        .o_valid       (o_valid),
        .o_out_row     (o_out_row),
        .o_out_col     (o_out_col),
        .o_result_value(o_result_value),
        .o_last        (o_last),
        .o_status      (o_status),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data)
    );

    // Free-running clock.
    always #1 i_clk = ~i_clk;

    // A size register of 0 acts as 1 and any value above the store size as the store size.
    function automatic int eff_size(logic [mase_pkg::CFG_DIM_W-1:0] v);
        if (v == 0) begin
            return 1;
        end else if (v > MAX_DIM) begin
            return MAX_DIM;
        end
        return int'(v);
    endfunction

    // Compute the result words caused by one accepted command word.
    task automatic calc_command(t_cmd_word c);
        int ra, ca, rb, cb, nr, nc;
        logic [mase_pkg::WORD_W-1:0] acc;
        t_elem_word w;
        bit sizes_ok;
        case (c.op)
            mase_pkg::OP_LOAD_A: calc_a[c.row * MAX_DIM + c.col] = c.value;
            mase_pkg::OP_LOAD_B: calc_b[c.row * MAX_DIM + c.col] = c.value;
            mase_pkg::OP_START: begin
                if (calc_cfg.mode != mase_pkg::MODE_UNUSED) begin
                    ra = eff_size(calc_cfg.rows_a);
                    ca = eff_size(calc_cfg.cols_a);
                    rb = eff_size(calc_cfg.rows_b);
                    cb = eff_size(calc_cfg.cols_b);
                    if (calc_cfg.mode == mase_pkg::MODE_MUL) begin
                        sizes_ok = (ca == rb);
                        nr = ra;
                        nc = cb;
                    end else begin
                        sizes_ok = (ra == rb) && (ca == cb);
                        nr = ra;
                        nc = ca;
                    end
                    if (!sizes_ok) begin
                        w = '{row: '0, col: '0, value: '0, last: 1'b1, status: 1'b1};
                        elem_q.push_back(w);
                    end else begin
                        for (int i = 0; i < nr; i++) begin
                            for (int j = 0; j < nc; j++) begin
                                if (calc_cfg.mode == mase_pkg::MODE_ADD) begin
                                    acc = calc_a[i * MAX_DIM + j] + calc_b[i * MAX_DIM + j];
                                end else if (calc_cfg.mode == mase_pkg::MODE_SUB) begin
                                    acc = calc_a[i * MAX_DIM + j] - calc_b[i * MAX_DIM + j];
                                end else begin
                                    acc = '0;
                                    for (int k = 0; k < ca; k++) begin
                                        acc = acc + calc_a[i * MAX_DIM + k] *
                                                    calc_b[k * MAX_DIM + j];
                                    end
                                end
                                w.row    = i[mase_pkg::POS_W-1:0];
                                w.col    = j[mase_pkg::POS_W-1:0];
                                w.value  = acc;
                                w.last   = (i == nr - 1) && (j == nc - 1);
                                w.status = 1'b0;
                                elem_q.push_back(w);
                            end
                        end
                    end
                end
            end
            default: ;
        endcase
    endtask

    // Register writes seen by the block are mirrored into the calculator.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            calc_cfg <= '{rows_a: 4'd1, cols_a: 4'd1, rows_b: 4'd1, cols_b: 4'd1,
                          mode: mase_pkg::MODE_ADD};
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                mase_pkg::CFG_ROWS_A: calc_cfg.rows_a <= i_cfg_data;
                mase_pkg::CFG_COLS_A: calc_cfg.cols_a <= i_cfg_data;
                mase_pkg::CFG_ROWS_B: calc_cfg.rows_b <= i_cfg_data;
                mase_pkg::CFG_COLS_B: calc_cfg.cols_b <= i_cfg_data;
                mase_pkg::CFG_MODE:   calc_cfg.mode   <= i_cfg_data[mase_pkg::CFG_MODE_W-1:0];
                default: ;
            endcase
        end
    end

    // Command driver: a word is taken when start is high and busy is low.
    always @(posedge i_clk) begin : cmd_driver
        t_cmd_word cur;
        t_cmd_word nxt;
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            if (start && !busy) begin
                cur.op    = i_operation;
                cur.row   = i_row;
                cur.col   = i_col;
                cur.value = i_value;
                calc_command(cur);
            end
            if (!start || !busy) begin
                if (cmd_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    nxt = cmd_q.pop_front();
                    start       <= 1'b1;
                    i_operation <= nxt.op;
                    i_row       <= nxt.row;
                    i_col       <= nxt.col;
                    i_value     <= nxt.value;
                end else begin
                    start <= 1'b0;
                end
            end
        end
    end

    // Result monitor: every strobed word is checked against the oldest prediction.
    always @(posedge i_clk) begin : elem_monitor
        t_elem_word want;
        if (i_rst_n && o_valid) begin
            if (elem_q.size() == 0) begin
                error_count++;
                $display("%0t: unexpected result word row=%0d col=%0d value=%h last=%b status=%b",
                         $time, o_out_row, o_out_col, o_result_value, o_last, o_status);
            end else begin
                want = elem_q.pop_front();
                if ({want.row, want.col, want.value, want.last, want.status} !==
                    {o_out_row, o_out_col, o_result_value, o_last, o_status}) begin
                    error_count++;
                    $display("%0t: mismatch expected row=%0d col=%0d value=%h last=%b status=%b",
                             $time, want.row, want.col, want.value, want.last, want.status);
                    $display("%0t:          actual   row=%0d col=%0d value=%h last=%b status=%b",
                             $time, o_out_row, o_out_col, o_result_value, o_last,
                             o_status);
                end
            end
        end
    end

    // Wait until every queued word was taken and every prediction has arrived.
    task automatic drain();
        do @(negedge i_clk);
        while (cmd_q.size() != 0 || start || elem_q.size() != 0);
    endtask

    // Block idle: drained, busy low, then a pause for work that gives no word.
    task automatic wait_idle();
        drain();
        while (busy) @(negedge i_clk);
        repeat (8) @(negedge i_clk);
    endtask

    task automatic write_reg(logic [mase_pkg::CFG_IDX_W-1:0] idx,
                             logic [mase_pkg::CFG_DATA_W-1:0] data);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
    endtask

    // Write all five registers while the block is idle.
    task automatic set_config(logic [mase_pkg::CFG_DIM_W-1:0] ra,
                              logic [mase_pkg::CFG_DIM_W-1:0] ca,
                              logic [mase_pkg::CFG_DIM_W-1:0] rb,
                              logic [mase_pkg::CFG_DIM_W-1:0] cb,
                              logic [mase_pkg::CFG_MODE_W-1:0] md);
        logic [1:0] junk;
        wait_idle();
        junk = 2'($urandom_range(0, 3));
        write_reg(mase_pkg::CFG_ROWS_A, ra);
        write_reg(mase_pkg::CFG_COLS_A, ca);
        write_reg(mase_pkg::CFG_ROWS_B, rb);
        write_reg(mase_pkg::CFG_COLS_B, cb);
        // Upper data bits of the mode write are don't-care.
        write_reg(mase_pkg::CFG_MODE, {junk, md});
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        gen_ra   = eff_size(ra);
        gen_ca   = eff_size(ca);
        gen_rb   = eff_size(rb);
        gen_cb   = eff_size(cb);
        gen_mode = md;
        @(negedge i_clk);
    endtask

    function automatic logic [mase_pkg::WORD_W-1:0] rand_word();
        case ($urandom_range(0, 7))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return 32'hFFFF_FFFF;
            3: return 32'h0000_0000;
            4: return $urandom_range(0, 15);
            default: return $urandom();
        endcase
    endfunction

    task automatic push_load(logic [mase_pkg::OP_W-1:0] op, int row, int col,
                             logic [mase_pkg::WORD_W-1:0] v);
        t_cmd_word c;
        c.op    = op;
        c.row   = row[mase_pkg::POS_W-1:0];
        c.col   = col[mase_pkg::POS_W-1:0];
        c.value = v;
        cmd_q.push_back(c);
        if (op == mase_pkg::OP_LOAD_A) a_loaded[row * MAX_DIM + col] = 1'b1;
        if (op == mase_pkg::OP_LOAD_B) b_loaded[row * MAX_DIM + col] = 1'b1;
    endtask

    task automatic push_noise();
        t_cmd_word c;
        c.op    = OP_UNUSED;
        c.row   = mase_pkg::POS_W'($urandom_range(0, 7));
        c.col   = mase_pkg::POS_W'($urandom_range(0, 7));
        c.value = $urandom();
        cmd_q.push_back(c);
    endtask

    // Load any never-written element of the region a start will read.
    task automatic fill_region(bit is_b, int nr, int nc);
        for (int i = 0; i < nr; i++) begin
            for (int j = 0; j < nc; j++) begin
                if (is_b && !b_loaded[i * MAX_DIM + j]) begin
                    push_load(mase_pkg::OP_LOAD_B, i, j, rand_word());
                end else if (!is_b && !a_loaded[i * MAX_DIM + j]) begin
                    push_load(mase_pkg::OP_LOAD_A, i, j, rand_word());
                end
            end
        end
    endtask

    task automatic push_start();
        t_cmd_word c;
        if (gen_mode == mase_pkg::MODE_MUL) begin
            if (gen_ca == gen_rb) begin
                fill_region(1'b0, gen_ra, gen_ca);
                fill_region(1'b1, gen_ca, gen_cb);
            end
        end else if (gen_mode != mase_pkg::MODE_UNUSED) begin
            if (gen_ra == gen_rb && gen_ca == gen_cb) begin
                fill_region(1'b0, gen_ra, gen_ca);
                fill_region(1'b1, gen_ra, gen_ca);
            end
        end
        c.op    = mase_pkg::OP_START;
        c.row   = mase_pkg::POS_W'($urandom_range(0, 7));
        c.col   = mase_pkg::POS_W'($urandom_range(0, 7));
        c.value = $urandom();
        cmd_q.push_back(c);
    endtask

    // Mostly small sizes, sometimes zero, the largest or an out-of-range encoding.
    function automatic logic [mase_pkg::CFG_DIM_W-1:0] pick_size();
        case ($urandom_range(0, 19))
            0: return 4'd0;
            1: return mase_pkg::CFG_DIM_W'($urandom_range(9, 15));
            2: return 4'd8;
            default: return mase_pkg::CFG_DIM_W'($urandom_range(1, 3));
        endcase
    endfunction

    // Stimulus.
    initial begin : stimulus
        int idle_table[4] = '{0, 47, 0, 36};
        int n_items, pick, shape;
        bit is_b;
        logic [mase_pkg::CFG_DIM_W-1:0] ra, ca, rb, cb;
        logic [mase_pkg::CFG_MODE_W-1:0] md;

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Add at reset sizes: positive overflow wraps to the most negative value.
        push_load(mase_pkg::OP_LOAD_A, 0, 0, 32'h7FFF_FFFF);
        push_load(mase_pkg::OP_LOAD_B, 0, 0, 32'h0000_0001);
        push_noise();
        push_start();

        // Zero size registers act as one; subtract wraps the other way.
        set_config(4'd0, 4'd0, 4'd0, 4'd0, mase_pkg::MODE_SUB);
        push_load(mase_pkg::OP_LOAD_A, 0, 0, 32'h8000_0000);
        push_load(mase_pkg::OP_LOAD_B, 0, 0, 32'h0000_0001);
        push_start();

        // Small product with extreme operands; far corner elements loaded too.
        set_config(4'd1, 4'd2, 4'd2, 4'd1, mase_pkg::MODE_MUL);
        push_load(mase_pkg::OP_LOAD_A, 0, 0, 32'hFFFF_FFFF);
        push_load(mase_pkg::OP_LOAD_A, 0, 1, 32'h7FFF_FFFF);
        push_load(mase_pkg::OP_LOAD_B, 0, 0, 32'hFFFF_FFFF);
        push_load(mase_pkg::OP_LOAD_B, 1, 0, 32'h0000_0002);
        push_load(mase_pkg::OP_LOAD_A, 7, 7, 32'h5555_5555);
        push_load(mase_pkg::OP_LOAD_B, 7, 7, 32'hAAAA_AAAA);
        push_start();

        // Size mismatch for add, size mismatch for multiply, and the unused mode.
        set_config(4'd2, 4'd1, 4'd3, 4'd1, mase_pkg::MODE_ADD);
        push_start();
        set_config(4'd1, 4'd2, 4'd3, 4'd1, mase_pkg::MODE_MUL);
        push_start();
        set_config(4'd1, 4'd1, 4'd1, 4'd1, mase_pkg::MODE_UNUSED);
        push_start();

        // Randomized phases.
        for (int ph = 0; ph < 8; ph++) begin
            if (ph == 0) begin
                // Full-size add, columns of A and rows of B given as out-of-range encodings.
                set_config(4'd8, 4'd15, 4'd15, 4'd8, mase_pkg::MODE_ADD);
                n_items = 4;
            end else if (ph == 1) begin
                // Full-size product: the longest computation.
                set_config(4'd15, 4'd8, 4'd8, 4'd15, mase_pkg::MODE_MUL);
                n_items = 4;
            end else begin
                shape = $urandom_range(0, 9);
                md    = mase_pkg::CFG_MODE_W'($urandom_range(0, 2));
                ra    = pick_size();
                ca    = pick_size();
                if (shape <= 6) begin
                    if (md == mase_pkg::MODE_MUL) begin
                        rb = ca;
                        cb = pick_size();
                    end else begin
                        rb = ra;
                        cb = ca;
                    end
                end else begin
                    ra = mase_pkg::CFG_DIM_W'($urandom_range(0, 15));
                    ca = mase_pkg::CFG_DIM_W'($urandom_range(0, 15));
                    rb = mase_pkg::CFG_DIM_W'($urandom_range(0, 15));
                    cb = mase_pkg::CFG_DIM_W'($urandom_range(0, 15));
                    if (shape == 9) md = mase_pkg::MODE_UNUSED;
                end
                set_config(ra, ca, rb, cb, md);
                n_items = 6;
            end
            send_idle_pct = idle_table[ph % 4];

            for (int k = 0; k < n_items; k++) begin
                // Sender holds off once until every prediction has come out.
                if (ph == 3 && k == n_items / 2) drain();
                pick = $urandom_range(0, 99);
                is_b = 1'($urandom_range(0, 1));
                if (pick < 50) begin
                    if (is_b) begin
                        push_load(mase_pkg::OP_LOAD_B, $urandom_range(0, gen_rb - 1),
                                  $urandom_range(0, gen_cb - 1), rand_word());
                    end else begin
                        push_load(mase_pkg::OP_LOAD_A, $urandom_range(0, gen_ra - 1),
                                  $urandom_range(0, gen_ca - 1), rand_word());
                    end
                end else if (pick < 62) begin
                    push_load(is_b ? mase_pkg::OP_LOAD_B : mase_pkg::OP_LOAD_A,
                              $urandom_range(0, 7), $urandom_range(0, 7), rand_word());
                end else if (pick < 67) begin
                    push_noise();
                end else begin
                    push_start();
                end
            end
            push_start();
        end

        // Let everything come out, then give the block time to settle.
        wait_idle();
        if (error_count == 0) begin
            $display("[matrix_add_sub_mul_engine_top] OK");
        end else begin
            $display("[matrix_add_sub_mul_engine_top] ERROR");
        end
        $finish;
    end

    // Watchdog.
    initial begin : watchdog
        #1_000_000;
        $display("[matrix_add_sub_mul_engine_top] ERROR");
        $finish;
    end

endmodule
